>>> src/lru_cache_replacement_defines.svh
// Assertion macros shared by the LRU cache replacement block.
`ifndef LRU_CACHE_REPLACEMENT_DEFINES_SVH
`define LRU_CACHE_REPLACEMENT_DEFINES_SVH

// Immediate-consequence property, checked at every rising clock edge out of reset.
`define LCR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("lru cache replacement assertion failed");

// Next-cycle property, checked at every rising clock edge out of reset.
`define LCR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lru cache replacement assertion failed");

`endif

>>> src/lcr_pkg.sv
// Package with sizes, operation codes and types of the LRU cache replacement block.
package lcr_pkg;

  localparam int CAPACITY   = 16;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int KEY_W      = 31;
  localparam int FUNC_W     = 2;
  localparam int LIMIT_W    = 5;
  localparam int OCC_W      = 5;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 40;

  typedef logic [FUNC_W-1:0] func_t;

  localparam func_t FUNC_ACCESS = 2'd0;
  localparam func_t FUNC_INSERT = 2'd1;
  localparam func_t FUNC_REMOVE = 2'd2;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(CAPACITY);

endpackage

>>> src/lcr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module lcr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> src/lru_cache_replacement.sv
// Top level of the LRU cache replacement tracker.
// The block tracks up to 16 keys with their recency order and takes one operation per
// input word: access, insert or remove. A single key comparator scans the key memory one
// slot per cycle over all 16 slots, and the update state then applies the rank update and
// loads the result. The result is valid and the block is ready again once the update state
// has loaded it; a new word is not taken until the previous one has been through the update
// state. A new word is taken while the previous result still waits on the output side, but
// its update state then waits until that result has been accepted.
// The cache limit register may be written only while no word is in flight.
`include "lru_cache_replacement_defines.svh"

module lru_cache_replacement (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [lcr_pkg::LIMIT_W-1:0]     cfg_wdata,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [lcr_pkg::IN_DATA_W-1:0]   in_tdata,   // key[30:0], zero[31]
  input  logic [lcr_pkg::FUNC_W-1:0]      in_tuser,   // func[1:0]
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [lcr_pkg::OUT_DATA_W-1:0]  out_tdata,  // evicted_key[30:0], occupancy[35:31]
  output logic [1:0]                      out_tuser   // hit[0], evicted_valid[1]
);

  localparam int CAP   = lcr_pkg::CAPACITY;
  localparam int IDX_W = lcr_pkg::IDX_W;
  localparam int CNT_W = lcr_pkg::CNT_W;
  localparam int KEY_W = lcr_pkg::KEY_W;
  localparam int OCC_W = lcr_pkg::OCC_W;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_UPDATE} state_t;

  state_t                      state_r, state_nxt;
  lcr_pkg::func_t              func_r, func_nxt;
  logic [KEY_W-1:0]            key_r, key_nxt;
  logic [IDX_W-1:0]            scan_idx_r, scan_idx_nxt;
  logic                        hit_r, hit_nxt;
  logic [IDX_W-1:0]            slot_r, slot_nxt;
  logic                        free_found_r, free_found_nxt;
  logic [IDX_W-1:0]            free_r, free_nxt;
  logic [KEY_W-1:0]            old_key_r, old_key_nxt;
  logic [CAP-1:0]              valid_r, valid_nxt;
  logic [IDX_W-1:0]            rank_r [CAP];
  logic [IDX_W-1:0]            rank_nxt [CAP];
  logic [CNT_W-1:0]            held_r, held_nxt;
  logic [lcr_pkg::LIMIT_W-1:0] limit_r, limit_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic                        out_hit_r, out_hit_nxt;
  logic                        out_ev_r, out_ev_nxt;
  logic [KEY_W-1:0]            out_evkey_r, out_evkey_nxt;
  logic [OCC_W-1:0]            out_occ_r, out_occ_nxt;

  logic [CNT_W-1:0]            lim;
  logic [CNT_W-1:0]            lim_m1;
  logic                        evict_on;
  logic [KEY_W-1:0]            rd_key;
  logic                        cur_valid;
  logic [CNT_W-1:0]            cur_rank;
  logic                        cur_match;
  logic                        cur_oldest;
  logic                        cur_free;
  logic                        out_free;
  logic [IDX_W-1:0]            slot_rank;
  logic                        ram_we;

  lcr_ram #(
    .WIDTH(KEY_W),
    .DEPTH(CAP)
  ) u_key_ram (
    .clk    (clk),
    .wr_en  (ram_we),
    .wr_addr(free_r),
    .wr_data(key_r),
    .rd_addr(scan_idx_nxt),
    .rd_data(rd_key)
  );

  always_comb begin
    if (limit_r == '0) begin
      lim = CNT_W'(1);
    end else if (32'(limit_r) > 32'(CAP)) begin
      lim = CNT_W'(CAP);
    end else begin
      lim = CNT_W'(limit_r);
    end
  end

  assign lim_m1     = lim - CNT_W'(1);
  assign evict_on   = held_r >= lim;
  assign cur_valid  = valid_r[scan_idx_r];
  assign cur_rank   = CNT_W'(rank_r[scan_idx_r]);
  assign cur_match  = cur_valid && (rd_key == key_r);
  assign cur_oldest = cur_valid && ((cur_rank + CNT_W'(1)) == held_r);
  assign cur_free   = !cur_valid || (evict_on && (cur_rank >= lim_m1));
  assign out_free   = !out_valid_r || out_tready;
  assign slot_rank  = rank_r[slot_r];
  assign ram_we     = (state_r == S_UPDATE) && out_free &&
                      (func_r == lcr_pkg::FUNC_INSERT) && !hit_r;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tuser  = {out_ev_r, out_hit_r};
  assign out_tdata  = {{(lcr_pkg::OUT_DATA_W - KEY_W - OCC_W){1'b0}}, out_occ_r, out_evkey_r};

  always_comb begin
    state_nxt      = state_r;
    func_nxt       = func_r;
    key_nxt        = key_r;
    scan_idx_nxt   = scan_idx_r;
    hit_nxt        = hit_r;
    slot_nxt       = slot_r;
    free_found_nxt = free_found_r;
    free_nxt       = free_r;
    old_key_nxt    = old_key_r;
    valid_nxt      = valid_r;
    rank_nxt       = rank_r;
    held_nxt       = held_r;
    limit_nxt      = cfg_we ? cfg_wdata : limit_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_hit_nxt    = out_hit_r;
    out_ev_nxt     = out_ev_r;
    out_evkey_nxt  = out_evkey_r;
    out_occ_nxt    = out_occ_r;

    case (state_r)
      S_IDLE: begin
        scan_idx_nxt = '0;
        if (in_tvalid) begin
          func_nxt       = in_tuser;
          key_nxt        = in_tdata[KEY_W-1:0];
          hit_nxt        = 1'b0;
          free_found_nxt = 1'b0;
          state_nxt      = S_SCAN;
        end
      end
      S_SCAN: begin
        if (cur_match) begin
          hit_nxt  = 1'b1;
          slot_nxt = scan_idx_r;
        end
        if (cur_oldest) begin
          old_key_nxt = rd_key;
        end
        if (cur_free && !free_found_r) begin
          free_nxt       = scan_idx_r;
          free_found_nxt = 1'b1;
        end
        if (scan_idx_r == IDX_W'(CAP - 1)) begin
          scan_idx_nxt = '0;
          state_nxt    = S_UPDATE;
        end else begin
          scan_idx_nxt = scan_idx_r + IDX_W'(1);
        end
      end
      S_UPDATE: begin
        scan_idx_nxt = '0;
        if (out_free) begin
          out_ev_nxt    = 1'b0;
          out_evkey_nxt = '0;
          out_hit_nxt   = hit_r;
          case (func_r)
            lcr_pkg::FUNC_ACCESS, lcr_pkg::FUNC_INSERT: begin
              if (hit_r) begin
                for (int i = 0; i < CAP; i++) begin
                  if (valid_r[i] && (rank_r[i] < slot_rank)) begin
                    rank_nxt[i] = rank_r[i] + IDX_W'(1);
                  end
                end
                rank_nxt[slot_r] = '0;
              end else if (func_r == lcr_pkg::FUNC_INSERT) begin
                for (int i = 0; i < CAP; i++) begin
                  valid_nxt[i] = valid_r[i] &&
                                 !(evict_on && (CNT_W'(rank_r[i]) >= lim_m1));
                  if (valid_nxt[i]) begin
                    rank_nxt[i] = rank_r[i] + IDX_W'(1);
                  end
                end
                valid_nxt[free_r] = 1'b1;
                rank_nxt[free_r]  = '0;
                held_nxt          = (evict_on ? lim_m1 : held_r) + CNT_W'(1);
                if (evict_on) begin
                  out_ev_nxt    = 1'b1;
                  out_evkey_nxt = old_key_r;
                end
              end
            end
            lcr_pkg::FUNC_REMOVE: begin
              if (hit_r) begin
                valid_nxt[slot_r] = 1'b0;
                for (int i = 0; i < CAP; i++) begin
                  if (valid_r[i] && (rank_r[i] > slot_rank)) begin
                    rank_nxt[i] = rank_r[i] - IDX_W'(1);
                  end
                end
                held_nxt = held_r - CNT_W'(1);
              end
            end
            default: begin
              out_hit_nxt = 1'b0;
            end
          endcase
          out_occ_nxt   = OCC_W'(held_nxt);
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      scan_idx_r   <= '0;
      hit_r        <= 1'b0;
      free_found_r <= 1'b0;
      valid_r      <= '0;
      for (int i = 0; i < CAP; i++) begin
        rank_r[i] <= '0;
      end
      held_r       <= '0;
      limit_r      <= lcr_pkg::LIMIT_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      scan_idx_r   <= scan_idx_nxt;
      hit_r        <= hit_nxt;
      free_found_r <= free_found_nxt;
      valid_r      <= valid_nxt;
      rank_r       <= rank_nxt;
      held_r       <= held_nxt;
      limit_r      <= limit_nxt;
      out_valid_r  <= out_valid_nxt;
      func_r       <= func_nxt;
      key_r        <= key_nxt;
      slot_r       <= slot_nxt;
      free_r       <= free_nxt;
      old_key_r    <= old_key_nxt;
      out_hit_r    <= out_hit_nxt;
      out_ev_r     <= out_ev_nxt;
      out_evkey_r  <= out_evkey_nxt;
      out_occ_r    <= out_occ_nxt;
    end
  end

  `LCR_ASSERT(a_held_matches_valid, held_r == CNT_W'($countones(valid_r)))
  `LCR_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready)
  `LCR_ASSERT(a_evict_only_on_miss, (out_tvalid && out_tuser[1]) |-> !out_tuser[0])

endmodule

>>> verif/lru_checker.sv
// Checker that predicts and compares the results of the LRU cache replacement tracker.
`timescale 1ns / 100ps

module lru_checker
  import lcr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [LIMIT_W-1:0]     cfg_wdata,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_DATA_W-1:0]   in_tdata,
  input  logic [FUNC_W-1:0]      in_tuser,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_DATA_W-1:0]  out_tdata,
  input  logic [1:0]             out_tuser,
  output int                     fail_count,
  output int                     outstanding
);

  typedef struct packed {
    logic               hit;
    logic               ev_valid;
    logic [KEY_W-1:0]   ev_key;
    logic [OCC_W-1:0]   occ;
  } cache_result_t;

  logic [KEY_W-1:0]   slot_key [CAPACITY];
  logic               slot_used [CAPACITY];
  int                 slot_age [CAPACITY];
  int                 held;
  logic [LIMIT_W-1:0] cache_limit;
  cache_result_t      expected_results [$];

  function automatic int find_key(logic [KEY_W-1:0] k);
    int i;
    for (i = 0; i < CAPACITY; i++) begin
      if (slot_used[i] && slot_key[i] == k) return i;
    end
    return -1;
  endfunction

  function automatic void make_newest(int s);
    int i;
    int r;
    r = slot_age[s];
    for (i = 0; i < CAPACITY; i++) begin
      if (slot_used[i] && slot_age[i] < r) slot_age[i]++;
    end
    slot_age[s] = 0;
  endfunction

  function automatic void retire(int s);
    int i;
    int r;
    r = slot_age[s];
    slot_used[s] = 1'b0;
    for (i = 0; i < CAPACITY; i++) begin
      if (slot_used[i] && slot_age[i] > r) slot_age[i]--;
    end
    if (held > 0) held--;
  endfunction

  function automatic int oldest_slot();
    int i;
    for (i = 0; i < CAPACITY; i++) begin
      if (slot_used[i] && slot_age[i] + 1 == held) return i;
    end
    return -1;
  endfunction

  function automatic cache_result_t lru_apply(func_t op, logic [KEY_W-1:0] k);
    cache_result_t res;
    int s;
    int eff;
    int o;
    int i;
    int j;
    res = '0;
    eff = cache_limit;
    if (eff < 1) eff = 1;
    if (eff > CAPACITY) eff = CAPACITY;
    s = find_key(k);
    case (op)
      FUNC_ACCESS: begin
        if (s >= 0) begin
          res.hit = 1'b1;
          make_newest(s);
        end
      end
      FUNC_INSERT: begin
        if (s >= 0) begin
          res.hit = 1'b1;
          make_newest(s);
        end else begin
          o = 0;
          while (held >= eff && o >= 0) begin
            o = oldest_slot();
            if (o >= 0) begin
              if (!res.ev_valid) begin
                res.ev_valid = 1'b1;
                res.ev_key = slot_key[o];
              end
              retire(o);
            end
          end
          i = 0;
          while (i < CAPACITY && slot_used[i]) i++;
          if (i < CAPACITY) begin
            for (j = 0; j < CAPACITY; j++) begin
              if (slot_used[j]) slot_age[j]++;
            end
            slot_used[i] = 1'b1;
            slot_key[i] = k;
            slot_age[i] = 0;
            held++;
          end
        end
      end
      FUNC_REMOVE: begin
        if (s >= 0) begin
          res.hit = 1'b1;
          retire(s);
        end
      end
      default: begin
      end
    endcase
    res.occ = OCC_W'(held);
    return res;
  endfunction

  task automatic check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    cache_result_t want;
    int i;
    if (!rst_n) begin
      for (i = 0; i < CAPACITY; i++) begin
        slot_key[i] = '0;
        slot_used[i] = 1'b0;
        slot_age[i] = 0;
      end
      held = 0;
      cache_limit = LIMIT_RESET;
      expected_results.delete();
      fail_count = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual data 0x%0h user 0x%0h",
                   $time, out_tdata, out_tuser);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("hit", want.hit, out_tuser[0]);
          check_field("evicted_valid", want.ev_valid, out_tuser[1]);
          check_field("evicted_key", want.ev_key, out_tdata[KEY_W-1:0]);
          check_field("occupancy", want.occ, out_tdata[KEY_W +: OCC_W]);
        end
      end
      if (cfg_we) cache_limit = cfg_wdata;
      if (in_tvalid && in_tready) begin
        want = lru_apply(func_t'(in_tuser), in_tdata[KEY_W-1:0]);
        expected_results = {expected_results, want};
      end
    end
    outstanding = expected_results.size();
  end

endmodule

>>> verif/testbench.sv
// Testbench top that drives the LRU cache replacement tracker and reports the verdict.
`timescale 1ns / 100ps

module testbench;
  import lcr_pkg::*;

  localparam func_t FUNC_NONE = 2'd3;
  localparam int POOL_MAX = 24;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [LIMIT_W-1:0]    cfg_wdata;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [FUNC_W-1:0]     in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [1:0]            out_tuser;
  int                    fail_count;
  int                    outstanding;
  logic                  quiet;
  logic [KEY_W-1:0]      key_pool [POOL_MAX];
  int                    pool_n;
  logic [LIMIT_W-1:0]    phase_limits [10] = '{5'd16, 5'd31, 5'd1, 5'd0, 5'd2,
                                               5'd5, 5'd12, 5'd17, 5'd3, 5'd16};

  lru_cache_replacement dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  lru_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  initial begin
    #1_000_000;
    $display("TEST FAILED");
    $finish;
  end

  task automatic send_word(func_t op, logic [KEY_W-1:0] k);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 8);
    @(negedge clk);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= IN_DATA_W'(k);
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic set_limit(logic [LIMIT_W-1:0] v);
    @(negedge clk) in_tvalid <= 1'b0;
    wait (outstanding == 0);
    repeat (24) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk) cfg_we <= 1'b0;
  endtask

  function automatic func_t pick_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return FUNC_INSERT;
    if (r < 75) return FUNC_ACCESS;
    if (r < 95) return FUNC_REMOVE;
    return FUNC_NONE;
  endfunction

  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(0, 9) == 0) return KEY_W'($urandom);
    return key_pool[$urandom_range(0, pool_n - 1)];
  endfunction

  initial begin
    int stall;
    out_tready = 1'b0;
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 8);
      if (stall != 0) begin
        @(negedge clk) out_tready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk) out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  initial begin
    int ph;
    int n;
    int i;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = FUNC_ACCESS;
    quiet = 1'b0;
    pool_n = 2;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    send_word(FUNC_ACCESS, 31'h0000_0000);
    send_word(FUNC_INSERT, 31'h0000_0000);
    send_word(FUNC_INSERT, 31'h7FFF_FFFF);
    send_word(FUNC_ACCESS, 31'h0000_0000);
    send_word(FUNC_INSERT, 31'h7FFF_FFFF);
    send_word(FUNC_NONE, 31'h2AAA_AAAA);
    send_word(FUNC_REMOVE, 31'h5555_5555);
    send_word(FUNC_REMOVE, 31'h0000_0000);
    set_limit(5'd3);
    for (i = 1; i <= 4; i++) send_word(FUNC_INSERT, KEY_W'(i));
    set_limit(5'd1);
    send_word(FUNC_INSERT, 31'h5555_5555);
    set_limit(5'd0);
    send_word(FUNC_INSERT, 31'h2AAA_AAAA);
    send_word(FUNC_ACCESS, 31'h2AAA_AAAA);
    send_word(FUNC_REMOVE, 31'h2AAA_AAAA);

    for (ph = 0; ph < 10; ph++) begin
      set_limit(ph == 9 ? LIMIT_W'($urandom_range(0, 31)) : phase_limits[ph]);
      pool_n = $urandom_range(2, POOL_MAX);
      for (i = 0; i < POOL_MAX; i++) key_pool[i] = KEY_W'($urandom);
      for (n = 0; n < 150; n++) begin
        if (n % 50 == 0) quiet = ($urandom_range(0, 3) == 0);
        send_word(pick_op(), pick_key());
      end
    end

    @(negedge clk) in_tvalid <= 1'b0;
    quiet = 1'b0;
    wait (outstanding == 0);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+src
src/lcr_pkg.sv
src/lcr_ram.sv
src/lru_cache_replacement.sv
verif/lru_checker.sv
verif/testbench.sv
